// File: hdl/rbts_pkg.sv
// Shared types and constants of the relay bank timed scheduler.
package rbts_pkg;

	localparam int unsigned CHANNELS_DEF = 8;
	localparam logic [3:0] COUNT_RST = 4'd8;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;

	typedef enum logic [1:0] {
		OP_TOGGLE = 2'd0,
		OP_SET    = 2'd1,
		OP_SCHED  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCHED,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic sched;
		logic scan;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic arm;
		logic idx_end;
	} stat_t;

endpackage

// File: hdl/rbts_ctrl.sv
// Controller state machine of the relay bank timed scheduler.
module rbts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            operation,
	input  rbts_pkg::stat_t       stat,
	output rbts_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done
);

	rbts_pkg::state_t state_q;
	rbts_pkg::state_t state_d;
	rbts_pkg::op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbts_pkg::ST_IDLE;
			op_q    <= rbts_pkg::OP_TOGGLE;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= rbts_pkg::op_t'(operation);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = op_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			rbts_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rbts_pkg::ST_EXEC;
				end
			end
			rbts_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				case (op_q)
					rbts_pkg::OP_TOGGLE: state_d = stat.arm ? rbts_pkg::ST_SCAN : rbts_pkg::ST_DONE;
					rbts_pkg::OP_SCHED:  state_d = rbts_pkg::ST_SCHED;
					rbts_pkg::OP_TICK:   state_d = rbts_pkg::ST_SCAN;
					default:             state_d = rbts_pkg::ST_DONE;
				endcase
			end
			rbts_pkg::ST_SCHED: begin
				cmd.sched = 1'b1;
				if (stat.idx_end) begin
					state_d = rbts_pkg::ST_DONE;
				end
			end
			rbts_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.idx_end) begin
					state_d = rbts_pkg::ST_DONE;
				end
			end
			rbts_pkg::ST_DONE: begin
				done = 1'b1;
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rbts_pkg::ST_EXEC;
				end else begin
					state_d = rbts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbts_pkg::ST_IDLE;
			end
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == rbts_pkg::ST_EXEC))
		else $error("transfer accepted without entering execute");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rbts_pkg::ST_SCAN || state_q == rbts_pkg::ST_SCHED) && stat.idx_end)
		|=> done)
		else $error("channel sweep ended without a result");

endmodule

// File: hdl/rbts_dp.sv
// Datapath of the relay bank timed scheduler: relay state, off-time memory, alarm scan.
module rbts_dp #(
	parameter int unsigned CHANNELS = rbts_pkg::CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rbts_pkg::cmd_t        cmd,
	output rbts_pkg::stat_t       stat,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_data,
	input  logic [2:0]            channel,
	input  logic                  level,
	input  logic [7:0]            delay_minutes,
	input  logic [31:0]           now_time,
	input  logic [16:0]           second_of_day,
	input  logic [2:0]            day_of_week,
	input  logic [6:0]            day_mask,
	input  logic [10:0]           start_minute,
	input  logic [10:0]           end_minute,
	input  logic [7:0]            route_mask,
	output logic                  result_flag,
	output logic [7:0]            relay_mask,
	output logic                  alarm_update,
	output logic [31:0]           next_alarm
);

	localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [2:0]  ch_q;
	logic        level_q;
	logic [7:0]  delay_q;
	logic [31:0] now_q;
	logic [16:0] sod_q;
	logic [2:0]  dow_q;
	logic [6:0]  days_q;
	logic [10:0] startm_q;
	logic [10:0] endm_q;
	logic [7:0]  route_q;

	logic [3:0]  count_q;
	logic [7:0]  relay_on_q;
	logic [31:0] alarm_q;
	logic        flag_q;
	logic        upd_q;
	logic [3:0]  idx_q;
	logic [31:0] best_q;
	logic [CHANNELS-1:0] vld_q;

	logic [31:0] off_mem [CHANNELS];
	logic [31:0] rd_s1;
	logic        rd_ok_s1;
	logic        rd_v_s1;
	logic [2:0]  rd_idx_s1;

	logic [3:0]  n_used;
	logic        ch_ok;
	logic        idx_live;
	logic [13:0] arm_delay;
	logic [31:0] arm_time;
	logic [16:0] win_s;
	logic [16:0] win_e;
	logic        in_win;
	logic [2:0]  mon_day;
	logic        sched_ok;
	logic        route_hit;
	logic [31:0] off_rd;
	logic [31:0] age;
	logic [31:0] lead;
	logic        expired;
	logic        keep;
	logic        earlier;
	logic [31:0] best_d;
	logic        wr_en;
	logic [IW-1:0] wr_addr;

	always_comb begin
		n_used    = (count_q > 4'(CHANNELS)) ? 4'(CHANNELS) : count_q;
		ch_ok     = {1'b0, ch_q} < n_used;
		idx_live  = idx_q < n_used;
		stat.arm     = ch_ok && !relay_on_q[ch_q];
		stat.idx_end = idx_q == n_used;

		arm_delay = 14'(delay_q) * 14'(rbts_pkg::SEC_PER_MIN);
		arm_time  = now_q + 32'(arm_delay);

		win_s = 17'(startm_q) * 17'(rbts_pkg::SEC_PER_MIN);
		win_e = 17'(endm_q) * 17'(rbts_pkg::SEC_PER_MIN);
		if (win_s == win_e) begin
			in_win = 1'b1;
		end else if (win_s < win_e) begin
			in_win = (win_s <= sod_q) && (sod_q <= win_e);
		end else begin
			in_win = !((win_e <= sod_q) && (sod_q <= win_s));
		end
		mon_day   = (dow_q == 3'd0 || dow_q == 3'd7) ? 3'd6 : dow_q - 3'd1;
		sched_ok  = level_q && days_q[mon_day] && in_win;
		route_hit = sched_ok && route_q[idx_q[2:0]];

		off_rd  = rd_ok_s1 ? rd_s1 : '0;
		age     = now_q - off_rd;
		lead    = best_q - off_rd;
		expired = (cmd.op == rbts_pkg::OP_TICK) && !age[31];
		keep    = relay_on_q[rd_idx_s1] && !expired;
		earlier = (lead != '0) && !lead[31];
		best_d  = (rd_v_s1 && keep && earlier) ? off_rd : best_q;

		wr_en   = (cmd.exec && cmd.op == rbts_pkg::OP_TOGGLE && stat.arm)
			|| (cmd.sched && idx_live && route_hit);
		wr_addr = cmd.exec ? ch_q[IW-1:0] : idx_q[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q     <= channel;
			level_q  <= level;
			delay_q  <= delay_minutes;
			now_q    <= now_time;
			sod_q    <= second_of_day;
			dow_q    <= day_of_week;
			days_q   <= day_mask;
			startm_q <= start_minute;
			endm_q   <= end_minute;
			route_q  <= route_mask;
		end
		if (cmd.exec) begin
			best_q <= now_q + 32'(rbts_pkg::SEC_PER_DAY);
		end else if (cmd.scan) begin
			best_q <= best_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			off_mem[wr_addr] <= arm_time;
		end
		if (cmd.scan && idx_live) begin
			rd_s1     <= off_mem[idx_q[IW-1:0]];
			rd_ok_s1  <= vld_q[idx_q[IW-1:0]];
			rd_idx_s1 <= idx_q[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= rbts_pkg::COUNT_RST;
			relay_on_q <= '0;
			alarm_q    <= '0;
			flag_q     <= 1'b0;
			upd_q      <= 1'b0;
			idx_q      <= '0;
			vld_q      <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_v_s1 <= cmd.scan && idx_live;
			if (cmd.exec) begin
				idx_q <= '0;
				upd_q <= 1'b0;
				case (cmd.op)
					rbts_pkg::OP_TOGGLE: begin
						flag_q <= stat.arm;
						if (ch_ok) begin
							relay_on_q[ch_q] <= !relay_on_q[ch_q];
						end
					end
					rbts_pkg::OP_SET: begin
						flag_q <= ch_ok && level_q;
						if (ch_ok) begin
							relay_on_q[ch_q] <= level_q;
						end
					end
					rbts_pkg::OP_SCHED: begin
						flag_q <= sched_ok;
					end
					default: begin
						flag_q <= 1'b0;
					end
				endcase
			end
			if (cmd.sched && idx_live) begin
				idx_q <= idx_q + 4'd1;
				if (route_hit) begin
					relay_on_q[idx_q[2:0]] <= 1'b1;
				end
			end
			if (cmd.scan) begin
				if (idx_live) begin
					idx_q <= idx_q + 4'd1;
				end
				if (rd_v_s1 && relay_on_q[rd_idx_s1] && expired) begin
					relay_on_q[rd_idx_s1] <= 1'b0;
				end
				if (stat.idx_end) begin
					alarm_q <= best_d;
					upd_q   <= 1'b1;
				end
			end
		end
	end

	assign result_flag  = flag_q;
	assign relay_mask   = relay_on_q;
	assign alarm_update = upd_q;
	assign next_alarm   = alarm_q;

endmodule

// File: hdl/relay_bank_timed_scheduler_unit.sv
// Relay bank timed scheduler: top level joining controller and datapath.
// Usage: drive the command fields and pulse start while busy is low; the command
// transfers at that edge. One result per command appears for exactly one cycle with
// done high, on result_flag, relay_mask, alarm_update and next_alarm. The receiver
// cannot stall; results are never held.
// With n the channels in use (relay_count capped at CHANNELS): set, toggle to
// off and toggle of a channel outside n go from execute straight to the result;
// toggle to on and tick run the alarm scan over the n channels, and a schedule
// request runs the schedule sweep over them. The alarm scan reads one off-time
// entry per cycle from the off-time memory, which has separate write and read
// ports; the schedule sweep writes the off time of each routed channel on a match.
// busy drops in the result cycle, so the next command may transfer there.
// Users write relay_count via cfg_we/cfg_data while idle; this is not enforced.
// Reset: all relays off, off times read as zero, alarm zero, relay_count 8.
module relay_bank_timed_scheduler_unit #(
	parameter int unsigned CHANNELS = rbts_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic [1:0]  operation,
	input  logic [2:0]  channel,
	input  logic        level,
	input  logic [7:0]  delay_minutes,
	input  logic [31:0] now_time,
	input  logic [16:0] second_of_day,
	input  logic [2:0]  day_of_week,
	input  logic [6:0]  day_mask,
	input  logic [10:0] start_minute,
	input  logic [10:0] end_minute,
	input  logic [7:0]  route_mask,
	output logic        done,
	output logic        result_flag,
	output logic [7:0]  relay_mask,
	output logic        alarm_update,
	output logic [31:0] next_alarm
);

	rbts_pkg::cmd_t  cmd;
	rbts_pkg::stat_t stat;

	rbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	rbts_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.channel       (channel),
		.level         (level),
		.delay_minutes (delay_minutes),
		.now_time      (now_time),
		.second_of_day (second_of_day),
		.day_of_week   (day_of_week),
		.day_mask      (day_mask),
		.start_minute  (start_minute),
		.end_minute    (end_minute),
		.route_mask    (route_mask),
		.result_flag   (result_flag),
		.relay_mask    (relay_mask),
		.alarm_update  (alarm_update),
		.next_alarm    (next_alarm)
	);

endmodule

// File: verif/tb_relay_bank_timed_scheduler_unit.sv
// Self-checking testbench for the relay bank timed scheduler: directed table, then random phases.
module tb_relay_bank_timed_scheduler_unit;

	typedef struct packed {
		rbts_pkg::op_t op;
		logic [2:0]    ch;
		logic          lvl;
		logic [7:0]    dly;
		logic [31:0]   now;
		logic [16:0]   sod;
		logic [2:0]    dow;
		logic [6:0]    days;
		logic [10:0]   smin;
		logic [10:0]   emin;
		logic [7:0]    route;
	} relay_cmd_t;

	typedef struct packed {
		logic        flag;
		logic [7:0]  mask;
		logic        upd;
		logic [31:0] alarm;
	} relay_res_t;

	typedef struct packed {
		logic       is_cfg;
		logic [3:0] cfg;
		logic       typed;
		relay_cmd_t cmd;
		relay_res_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_we;
	logic [3:0]  cfg_data;
	logic [1:0]  operation;
	logic [2:0]  channel;
	logic        level;
	logic [7:0]  delay_minutes;
	logic [31:0] now_time;
	logic [16:0] second_of_day;
	logic [2:0]  day_of_week;
	logic [6:0]  day_mask;
	logic [10:0] start_minute;
	logic [10:0] end_minute;
	logic [7:0]  route_mask;
	logic        done;
	logic        result_flag;
	logic [7:0]  relay_mask;
	logic        alarm_update;
	logic [31:0] next_alarm;

	logic [7:0]  bank_on;
	logic [31:0] bank_off [0:7];
	logic [31:0] bank_alarm;
	logic [3:0]  bank_count;

	relay_res_t  relay_results_due [$];
	dir_row_t    dir_rows [$];
	relay_res_t  head;
	logic [3:0]  count_plan [0:5] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd8};
	logic [31:0] t_now;
	bit          idle_on;
	int          n_err;
	int          n_checked;
	int          n_sent;
	int          n_ticks;
	int          n_sched_hits;
	int          n_cfg;

	relay_bank_timed_scheduler_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.operation(operation),
		.channel(channel),
		.level(level),
		.delay_minutes(delay_minutes),
		.now_time(now_time),
		.second_of_day(second_of_day),
		.day_of_week(day_of_week),
		.day_mask(day_mask),
		.start_minute(start_minute),
		.end_minute(end_minute),
		.route_mask(route_mask),
		.done(done),
		.result_flag(result_flag),
		.relay_mask(relay_mask),
		.alarm_update(alarm_update),
		.next_alarm(next_alarm)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void refresh_alarm(input logic [31:0] now, input int n);
		logic [31:0] best;
		logic [31:0] gap;
		best = now + 32'(rbts_pkg::SEC_PER_DAY);
		for (int i = 0; i < n; i++) begin
			gap = best - bank_off[i];
			if (bank_on[i] && gap != 32'd0 && gap < 32'h8000_0000)
				best = bank_off[i];
		end
		bank_alarm = best;
	endfunction

	task automatic step_relay_bank(input relay_cmd_t c, output relay_res_t r);
		int          n;
		int          md;
		logic [31:0] arm_at;
		logic [31:0] s_sec;
		logic [31:0] e_sec;
		logic [31:0] age;
		logic        win;
		n = (bank_count > rbts_pkg::CHANNELS_DEF) ? int'(rbts_pkg::CHANNELS_DEF)
			: int'(bank_count);
		arm_at = c.now + 32'(c.dly) * 32'(rbts_pkg::SEC_PER_MIN);
		r = '0;
		case (c.op)
			rbts_pkg::OP_TOGGLE: begin
				if (int'(c.ch) < n) begin
					bank_on[c.ch] = ~bank_on[c.ch];
					if (bank_on[c.ch]) begin
						bank_off[c.ch] = arm_at;
						refresh_alarm(c.now, n);
						r.upd = 1'b1;
						r.flag = 1'b1;
					end
				end
			end
			rbts_pkg::OP_SET: begin
				if (int'(c.ch) < n) begin
					bank_on[c.ch] = c.lvl;
					r.flag = c.lvl;
				end
			end
			rbts_pkg::OP_SCHED: begin
				md = (int'(c.dow) + 6) % 7;
				s_sec = 32'(c.smin) * 32'(rbts_pkg::SEC_PER_MIN);
				e_sec = 32'(c.emin) * 32'(rbts_pkg::SEC_PER_MIN);
				if (s_sec == e_sec)
					win = 1'b1;
				else if (s_sec < e_sec)
					win = (s_sec <= 32'(c.sod)) && (32'(c.sod) <= e_sec);
				else
					win = !((e_sec <= 32'(c.sod)) && (32'(c.sod) <= s_sec));
				if (c.lvl && c.days[md] && win) begin
					for (int i = 0; i < n; i++) begin
						if (c.route[i]) begin
							bank_on[i] = 1'b1;
							bank_off[i] = arm_at;
						end
					end
					r.flag = 1'b1;
					n_sched_hits++;
				end
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					age = c.now - bank_off[i];
					if (bank_on[i] && age < 32'h8000_0000)
						bank_on[i] = 1'b0;
				end
				refresh_alarm(c.now, n);
				r.upd = 1'b1;
				n_ticks++;
			end
		endcase
		r.mask = bank_on;
		r.alarm = bank_alarm;
	endtask

	// drive one command, hold it until the transfer, then log what it must produce
	task automatic send_cmd(input relay_cmd_t c, input logic typed, input relay_res_t want);
		relay_res_t r;
		operation <= c.op;
		channel <= c.ch;
		level <= c.lvl;
		delay_minutes <= c.dly;
		now_time <= c.now;
		second_of_day <= c.sod;
		day_of_week <= c.dow;
		day_mask <= c.days;
		start_minute <= c.smin;
		end_minute <= c.emin;
		route_mask <= c.route;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		step_relay_bank(c, r);
		relay_results_due.push_back(typed ? want : r);
		n_sent++;
	endtask

	task automatic maybe_idle();
		if (idle_on && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_count(input logic [3:0] v);
		start <= 1'b0;
		while (relay_results_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		bank_count = v;
		n_cfg++;
	endtask

	function automatic relay_cmd_t mk(input rbts_pkg::op_t op, input logic [2:0] ch,
			input logic lvl, input logic [7:0] dly, input logic [31:0] now,
			input logic [16:0] sod, input logic [2:0] dow, input logic [6:0] days,
			input logic [10:0] smin, input logic [10:0] emin, input logic [7:0] route);
		relay_cmd_t c;
		c.op = op;
		c.ch = ch;
		c.lvl = lvl;
		c.dly = dly;
		c.now = now;
		c.sod = sod;
		c.dow = dow;
		c.days = days;
		c.smin = smin;
		c.emin = emin;
		c.route = route;
		return c;
	endfunction

	task automatic put_row(input relay_cmd_t c, input logic typed, input logic flag,
			input logic [7:0] mask, input logic upd, input logic [31:0] alarm);
		dir_row_t row;
		row = '0;
		row.cmd = c;
		row.typed = typed;
		row.want.flag = flag;
		row.want.mask = mask;
		row.want.upd = upd;
		row.want.alarm = alarm;
		dir_rows.push_back(row);
	endtask

	task automatic put_cfg(input logic [3:0] v);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg = v;
		dir_rows.push_back(row);
	endtask

	task automatic rand_cmd(output relay_cmd_t c);
		int pick;
		int md;
		pick = $urandom_range(0, 99);
		c = '0;
		if (pick < 28)
			c.op = rbts_pkg::OP_TOGGLE;
		else if (pick < 48)
			c.op = rbts_pkg::OP_SET;
		else if (pick < 70)
			c.op = rbts_pkg::OP_SCHED;
		else
			c.op = rbts_pkg::OP_TICK;
		c.ch = 3'($urandom_range(0, 7));
		c.lvl = (c.op == rbts_pkg::OP_SCHED) ? ($urandom_range(0, 99) < 85)
			: 1'($urandom_range(0, 1));
		c.dly = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 20)) : 8'($urandom);
		if ($urandom_range(0, 99) < 3)
			t_now = $urandom;
		else
			t_now = t_now + 32'($urandom_range(0, 900));
		c.now = t_now;
		if (c.op == rbts_pkg::OP_TICK && $urandom_range(0, 99) < 25)
			c.now = bank_off[$urandom_range(0, 7)] + 32'($urandom_range(0, 2)) - 32'd1;
		c.sod = ($urandom_range(0, 99) < 90) ? 17'($urandom_range(0, 86399))
			: 17'($urandom_range(0, 131071));
		c.dow = 3'($urandom_range(0, 7));
		c.days = 7'($urandom);
		md = (int'(c.dow) + 6) % 7;
		if ($urandom_range(0, 99) < 60)
			c.days[md] = 1'b1;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			c.smin = 11'($urandom);
			c.emin = 11'($urandom);
		end else begin
			c.smin = 11'($urandom_range(0, 1439));
			c.emin = (pick < 15) ? c.smin : 11'($urandom_range(0, 1439));
		end
		c.route = 8'($urandom);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (relay_results_due.size() == 0) begin
				$error("result transfer with no result outstanding");
				n_err++;
			end else begin
				head = relay_results_due.pop_front();
				n_checked++;
				if (result_flag !== head.flag) begin
					$error("result_flag: expected %0d, got %0d", head.flag, result_flag);
					n_err++;
				end
				if (relay_mask !== head.mask) begin
					$error("relay_mask: expected %02h, got %02h", head.mask, relay_mask);
					n_err++;
				end
				if (alarm_update !== head.upd) begin
					$error("alarm_update: expected %0d, got %0d", head.upd, alarm_update);
					n_err++;
				end
				if (next_alarm !== head.alarm) begin
					$error("next_alarm: expected %08h, got %08h", head.alarm, next_alarm);
					n_err++;
				end
			end
		end
	end

	initial begin
		relay_cmd_t c;
		relay_res_t none;
		logic [3:0] cnt;
		arst_n = 1'b0;
		start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= 4'd0;
		operation <= rbts_pkg::OP_TOGGLE;
		channel <= 3'd0;
		level <= 1'b0;
		delay_minutes <= 8'd0;
		now_time <= 32'd0;
		second_of_day <= 17'd0;
		day_of_week <= 3'd0;
		day_mask <= 7'd0;
		start_minute <= 11'd0;
		end_minute <= 11'd0;
		route_mask <= 8'd0;
		bank_on = 8'd0;
		for (int i = 0; i < 8; i++)
			bank_off[i] = 32'd0;
		bank_alarm = 32'd0;
		bank_count = rbts_pkg::COUNT_RST;
		none = '0;
		idle_on = 1'b1;
		t_now = $urandom;

		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd0, 0, 0, 0, 0, 0, 0),
			1, 0, 8'h00, 1, 32'd86400);
		put_row(mk(rbts_pkg::OP_SET, 7, 1, 0, 32'd0, 0, 0, 0, 0, 0, 0),
			1, 1, 8'h80, 0, 32'd86400);
		put_row(mk(rbts_pkg::OP_SET, 7, 0, 0, 32'd0, 0, 0, 0, 0, 0, 0),
			1, 0, 8'h00, 0, 32'd86400);
		put_row(mk(rbts_pkg::OP_TOGGLE, 0, 0, 255, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0),
			1, 1, 8'h01, 1, 32'd15299);
		put_row(mk(rbts_pkg::OP_TOGGLE, 0, 0, 255, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0),
			1, 0, 8'h00, 0, 32'd15299);
		put_row(mk(rbts_pkg::OP_TOGGLE, 3, 0, 0, 32'd1000, 0, 0, 0, 0, 0, 0),
			1, 1, 8'h08, 1, 32'd1000);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd1000, 0, 0, 0, 0, 0, 0),
			1, 0, 8'h00, 1, 32'd87400);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 1, 10, 32'd5000, 17'd40000, 1, 7'h01, 0, 0, 8'hFF),
			1, 1, 8'hFF, 0, 32'd87400);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd5599, 0, 0, 0, 0, 0, 0),
			1, 0, 8'hFF, 1, 32'd5600);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd5600, 0, 0, 0, 0, 0, 0),
			1, 0, 8'h00, 1, 32'd92000);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 0, 10, 32'd6000, 17'd40000, 1, 7'h7F, 0, 0, 8'hFF),
			1, 0, 8'h00, 0, 32'd92000);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 1, 10, 32'd6000, 17'd40000, 0, 7'h3F, 0, 0, 8'hFF),
			1, 0, 8'h00, 0, 32'd92000);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 1, 1, 32'd100, 17'd86399, 7, 7'h40,
			11'd1439, 11'd0, 8'h81), 1, 1, 8'h81, 0, 32'd92000);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 1, 1, 32'd100, 17'd131071, 1, 7'h7F,
			11'd0, 11'd1439, 8'h7E), 1, 0, 8'h81, 0, 32'd92000);
		put_row(mk(rbts_pkg::OP_SET, 5, 1, 0, 32'd0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_TOGGLE, 7, 0, 3, 32'd120, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd159, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_TOGGLE, 2, 0, 200, 32'h7FFF_FFF0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0, 0);
		put_cfg(4'd3);
		put_row(mk(rbts_pkg::OP_TOGGLE, 5, 0, 4, 32'd50, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_SET, 3, 1, 0, 32'd50, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_TOGGLE, 1, 0, 4, 32'd50, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_cfg(4'd0);
		put_row(mk(rbts_pkg::OP_TICK, 0, 0, 0, 32'd7, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_SET, 0, 1, 0, 32'd7, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		put_cfg(4'd15);
		put_row(mk(rbts_pkg::OP_TOGGLE, 7, 0, 255, 32'hFFFF_F000, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0, 0);
		put_row(mk(rbts_pkg::OP_SCHED, 0, 1, 2, 32'd300, 17'd6000, 2, 7'h02,
			11'd100, 11'd100, 8'hF0), 0, 0, 0, 0, 0);
		put_cfg(4'd8);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_count(dir_rows[i].cfg);
			end else begin
				send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
				maybe_idle();
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			cnt = (ph < 6) ? count_plan[ph] : 4'($urandom_range(0, 15));
			write_count(cnt);
			idle_on = (ph != 2);
			for (int k = 0; k < 145; k++) begin
				rand_cmd(c);
				send_cmd(c, 1'b0, none);
				maybe_idle();
			end
		end

		start <= 1'b0;
		while (relay_results_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		$display("covered %0d commands, %0d ticks, %0d schedule hits, %0d relay-count writes",
			n_sent, n_ticks, n_sched_hits, n_cfg);
		$display("checked %0d results, %0d field mismatches", n_checked, n_err);
		if (n_err == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
